[src/hsov_pkg.sv]
// Shared types, constants and SHA-1 round functions for the OTP verifier.
package hsov_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CODE_W     = 20;
  localparam int unsigned BIN_W      = 31;
  localparam int unsigned KEY_HIGH_W = 16;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;

  // request mode: moving value is a counter or Unix seconds
  typedef enum logic {OP_COUNTER = 1'b0, OP_TIME = 1'b1} op_t;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] MSG_END   = 8'h80;

  // Message lengths in bits, pad block included.
  localparam logic [63:0] INNER_LEN_BITS = 64'd576;
  localparam logic [63:0] OUTER_LEN_BITS = 64'd672;

  localparam int unsigned TIME_STEP = 30;
  localparam int unsigned REM_W     = 5;
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_CELLS = VALUE_W / DIV_BITS;

  localparam int unsigned MOD_STEPS = 2;
  localparam int unsigned MOD_CELLS = 32 / MOD_STEPS;

  localparam int unsigned SHA_ROUNDS = 80;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam longint unsigned CODE_LIMIT = 64'd1 << CODE_W;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha_state_t;

  typedef logic [15:0][31:0] win_t;

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] work;   // dividend bits out at the top, quotient bits in at the bottom
    logic [REM_W-1:0]   rem;
    logic [CODE_W-1:0]  cand;
  } div_item_t;

  typedef struct packed {
    sha_state_t        state;
    win_t              win;
    logic [CODE_W-1:0] cand;
  } sha_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]  r;
    logic [CODE_W-1:0] cand;
  } mod_item_t;

  typedef struct packed {
    logic              code_valid;
    logic [CODE_W-1:0] computed_code;
  } result_t;

  typedef struct packed {
    logic       busy;
    sha_state_t ipad_h;
    sha_state_t opad_h;
  } pad_state_t;

  localparam sha_state_t SHA_H0 = '{
    a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe, d: 32'h10325476, e: 32'hc3d2e1f0
  };

  function automatic sha_state_t sha_round(input sha_state_t s, input logic [31:0] w,
                                           input logic [6:0] idx);
    logic [31:0] f;
    logic [31:0] k;
    sha_state_t  r;
    if (idx < 7'd20) begin
      f = (s.b & s.c) | (~s.b & s.d);
      k = 32'h5a827999;
    end else if (idx < 7'd40) begin
      f = s.b ^ s.c ^ s.d;
      k = 32'h6ed9eba1;
    end else if (idx < 7'd60) begin
      f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
      k = 32'h8f1bbcdc;
    end else begin
      f = s.b ^ s.c ^ s.d;
      k = 32'hca62c1d6;
    end
    r.a = {s.a[26:0], s.a[31:27]} + f + s.e + k + w;
    r.b = s.a;
    r.c = {s.b[1:0], s.b[31:2]};
    r.d = s.c;
    r.e = s.d;
    return r;
  endfunction

  // Slide the 16-word schedule window by one word; element 0 is the current word.
  function automatic win_t sha_next_win(input win_t w);
    win_t        n;
    logic [31:0] x;
    for (int k = 0; k < 15; k++) begin
      n[k] = w[k+1];
    end
    x = w[13] ^ w[8] ^ w[2] ^ w[0];
    n[15] = {x[30:0], x[31]};
    return n;
  endfunction

  function automatic win_t blk_to_window(input logic [511:0] blk);
    win_t w;
    for (int k = 0; k < 16; k++) begin
      w[k] = blk[511-32*k -: 32];
    end
    return w;
  endfunction

  function automatic sha_state_t sha_add(input sha_state_t h, input sha_state_t s);
    sha_state_t r;
    r.a = h.a + s.a;
    r.b = h.b + s.b;
    r.c = h.c + s.c;
    r.d = h.d + s.d;
    r.e = h.e + s.e;
    return r;
  endfunction

endpackage

[src/hsov_if.sv]
// Request and result channel interfaces of the OTP verifier.
interface hsov_in_if;
  import hsov_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [VALUE_W-1:0] moving_value;
  logic [CODE_W-1:0]  candidate_code;

  modport source(output valid, op, moving_value, candidate_code, input ready);
  modport sink(input valid, op, moving_value, candidate_code, output ready);
endinterface

interface hsov_out_if;
  import hsov_pkg::*;

  logic              valid;
  logic              ready;
  logic              code_valid;
  logic [CODE_W-1:0] computed_code;

  modport source(output valid, code_valid, computed_code, input ready);
  modport sink(input valid, code_valid, computed_code, output ready);
endinterface

[src/hmac_sha1_otp_verifier.sv]
// Top level: HOTP/TOTP code check, HMAC-SHA1 as a chain of round cells.
// Throughput: one request per cycle while the buffer has room and pad hashing is done;
// 16 divide cells, 2x80 SHA-1 round cells and 16 modulo cells.
// The whole chain advances together and halts only while the 2-entry output buffer is full.
// Reset clears the key to zero; ipad then opad hashing runs with in_ch.ready low.
// Each key write repeats that hashing before new requests are taken.
module hmac_sha1_otp_verifier #(
  parameter int unsigned CODE_MODULUS = 1000000
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hsov_in_if.sink                         in_ch,
  hsov_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hsov_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsov_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hsov_pkg::*;

  pad_state_t pad;
  logic       en;
  logic       in_accept;

  logic       div_v [DIV_CELLS+1];
  div_item_t  div_i [DIV_CELLS+1];
  logic       inr_v [SHA_ROUNDS+1];
  sha_item_t  inr_i [SHA_ROUNDS+1];
  logic       out_v [SHA_ROUNDS+1];
  sha_item_t  out_i [SHA_ROUNDS+1];
  logic       mod_v [MOD_CELLS+1];
  mod_item_t  mod_i [MOD_CELLS+1];

  logic              dig_v_r;
  sha_state_t        dig_r;
  logic [CODE_W-1:0] dig_cand_r;
  logic              mac_v_r;
  logic [159:0]      mac_r;
  logic [CODE_W-1:0] mac_cand_r;
  logic              bin_v_r;
  mod_item_t         bin_r;

  logic [VALUE_W-1:0] factor;
  logic [7:0]         sel;
  logic [31:0]        trunc_word;

  logic [1:0] cnt_r;
  result_t    e0_r;
  result_t    e1_r;
  result_t    res;
  logic       push;
  logic       pop;

  hsov_key_engine u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pad       (pad)
  );

  // chain advances whenever the output buffer has room
  assign en           = (cnt_r != 2'd2);
  assign in_ch.ready  = en && !pad.busy;
  assign in_accept    = in_ch.valid && in_ch.ready;

  // time step division
  assign div_v[0]      = in_accept;
  assign div_i[0].op    = in_ch.op;
  assign div_i[0].value = in_ch.moving_value;
  assign div_i[0].work  = in_ch.moving_value;
  assign div_i[0].rem   = '0;
  assign div_i[0].cand  = in_ch.candidate_code;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    hsov_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (div_v[g]),
      .in_item   (div_i[g]),
      .out_valid (div_v[g+1]),
      .out_item  (div_i[g+1])
    );
  end

  // inner hash: ipad chaining value, then the padded 8-byte factor
  assign factor         = (div_i[DIV_CELLS].op == OP_TIME) ? div_i[DIV_CELLS].work
                                                           : div_i[DIV_CELLS].value;
  assign inr_v[0]       = div_v[DIV_CELLS];
  assign inr_i[0].state = pad.ipad_h;
  assign inr_i[0].win   = blk_to_window({factor, MSG_END, 376'b0, INNER_LEN_BITS});
  assign inr_i[0].cand  = div_i[DIV_CELLS].cand;

  for (genvar g = 0; g < SHA_ROUNDS; g++) begin : g_inner
    hsov_sha_cell #(.ROUND(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (inr_v[g]),
      .in_item   (inr_i[g]),
      .out_valid (inr_v[g+1]),
      .out_item  (inr_i[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_v_r <= 1'b0;
      mac_v_r <= 1'b0;
      bin_v_r <= 1'b0;
    end else if (en) begin
      dig_v_r <= inr_v[SHA_ROUNDS];
      mac_v_r <= out_v[SHA_ROUNDS];
      bin_v_r <= mac_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dig_r      <= sha_add(pad.ipad_h, inr_i[SHA_ROUNDS].state);
      dig_cand_r <= inr_i[SHA_ROUNDS].cand;
      mac_r      <= 160'(sha_add(pad.opad_h, out_i[SHA_ROUNDS].state));
      mac_cand_r <= out_i[SHA_ROUNDS].cand;
      bin_r.r    <= trunc_word[BIN_W-1:0];
      bin_r.cand <= mac_cand_r;
    end
  end

  // outer hash: opad chaining value, then the padded inner digest
  assign out_v[0]       = dig_v_r;
  assign out_i[0].state = pad.opad_h;
  assign out_i[0].win   = blk_to_window({160'(dig_r), MSG_END, 280'b0, OUTER_LEN_BITS});
  assign out_i[0].cand  = dig_cand_r;

  for (genvar g = 0; g < SHA_ROUNDS; g++) begin : g_outer
    hsov_sha_cell #(.ROUND(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (out_v[g]),
      .in_item   (out_i[g]),
      .out_valid (out_v[g+1]),
      .out_item  (out_i[g+1])
    );
  end

  // dynamic truncation: low nibble of the last byte picks a 4-byte window
  assign sel        = 8'd159 - {1'b0, mac_r[3:0], 3'b000};
  assign trunc_word = mac_r[sel -: 32];

  assign mod_v[0] = bin_v_r;
  assign mod_i[0] = bin_r;

  for (genvar g = 0; g < MOD_CELLS; g++) begin : g_mod
    hsov_mod_cell #(
      .CODE_MODULUS (CODE_MODULUS),
      .SHIFT        (31 - MOD_STEPS * g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (mod_v[g]),
      .in_item   (mod_i[g]),
      .out_valid (mod_v[g+1]),
      .out_item  (mod_i[g+1])
    );
  end

  assign res.computed_code = mod_i[MOD_CELLS].r[CODE_W-1:0];
  assign res.code_valid    = (mod_i[MOD_CELLS].cand == mod_i[MOD_CELLS].r[CODE_W-1:0]);

  // two-entry output buffer
  assign push = en && mod_v[MOD_CELLS];
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          e0_r <= res;
        end else begin
          e1_r <= res;
        end
      end
      2'b01:   e0_r <= e1_r;
      2'b11:   e0_r <= res;
      default: e0_r <= e0_r;
    endcase
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.code_valid    = e0_r.code_valid;
  assign out_ch.computed_code = e0_r.computed_code;

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("request taken right after a key write");

  a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer overflow");

  a_full_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && !out_ch.ready |=> (cnt_r == 2'd2) && $stable(e0_r))
    else $error("full output buffer changed without a pop");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (64'(CODE_MODULUS) > CODE_LIMIT) ||
                     ({44'b0, out_ch.computed_code} < 64'(CODE_MODULUS)))
    else $error("computed code not reduced below the modulus");
`endif

endmodule

[src/hsov_div_cell.sv]
// Divide-by-30 cell: four quotient bits per cycle while en is high, restoring.
module hsov_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  hsov_pkg::div_item_t in_item,
  output logic                out_valid,
  output hsov_pkg::div_item_t out_item
);
  import hsov_pkg::*;

  logic      valid_r;
  div_item_t item_r;
  div_item_t item_nxt;

  always_comb begin
    logic [REM_W:0] t;
    item_nxt = in_item;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {item_nxt.rem, item_nxt.work[VALUE_W-1]};
      if (t >= (REM_W+1)'(TIME_STEP)) begin
        item_nxt.rem  = REM_W'(t - (REM_W+1)'(TIME_STEP));
        item_nxt.work = {item_nxt.work[VALUE_W-2:0], 1'b1};
      end else begin
        item_nxt.rem  = t[REM_W-1:0];
        item_nxt.work = {item_nxt.work[VALUE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[src/hsov_sha_cell.sv]
// One SHA-1 round cell: state plus schedule window, one round per cycle while en is high.
module hsov_sha_cell #(
  parameter int unsigned ROUND = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  hsov_pkg::sha_item_t in_item,
  output logic                out_valid,
  output hsov_pkg::sha_item_t out_item
);
  import hsov_pkg::*;

  logic      valid_r;
  sha_item_t item_r;
  sha_item_t item_nxt;

  always_comb begin
    item_nxt.state = sha_round(in_item.state, in_item.win[0], 7'(ROUND));
    item_nxt.win   = sha_next_win(in_item.win);
    item_nxt.cand  = in_item.cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[src/hsov_mod_cell.sv]
// Modulo cell: two compare-and-subtract steps of the code reduction per cycle while en is high.
module hsov_mod_cell #(
  parameter int unsigned CODE_MODULUS = 1000000,
  parameter int unsigned SHIFT        = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  hsov_pkg::mod_item_t in_item,
  output logic                out_valid,
  output hsov_pkg::mod_item_t out_item
);
  import hsov_pkg::*;

  logic      valid_r;
  mod_item_t item_r;
  mod_item_t item_nxt;

  always_comb begin
    logic [63:0] sub;
    item_nxt = in_item;
    for (int j = 0; j < MOD_STEPS; j++) begin
      sub = 64'(CODE_MODULUS) << (SHIFT - j);
      // shifted modulus at or above 2^31 never fits and drops out here
      if (sub <= {{(64-BIN_W){1'b0}}, item_nxt.r}) begin
        item_nxt.r = item_nxt.r - sub[BIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[src/hsov_key_engine.sv]
// Key registers and iterative hashing of the ipad and opad blocks.
module hsov_key_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hsov_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsov_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hsov_pkg::pad_state_t                pad
);
  import hsov_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_IPAD, ST_OPAD, ST_READY} state_t;

  state_t                  state_r;
  logic [KEY_HIGH_W-1:0]   key_high_r;
  logic [VALUE_W-1:0]      key_low_r;
  logic [6:0]              round_r;
  sha_state_t              s_r;
  win_t                    w_r;
  sha_state_t              ipad_h_r;
  sha_state_t              opad_h_r;
  sha_state_t              s_step;

  function automatic logic [511:0] pad_block(input logic [KEY_HIGH_W-1:0] kh,
                                             input logic [VALUE_W-1:0] kl,
                                             input logic [7:0] pad_byte);
    return {kh, kl, 432'b0} ^ {64{pad_byte}};
  endfunction

  assign s_step = sha_round(s_r, w_r[0], round_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      key_high_r <= '0;
      key_low_r  <= '0;
      round_r    <= '0;
    end else if (cfg_we) begin
      // a key write restarts both pad hashes
      unique case (cfg_index)
        CFG_KEY_HIGH: key_high_r <= cfg_data[KEY_HIGH_W-1:0];
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        default:      key_low_r  <= key_low_r;
      endcase
      state_r <= ST_LOAD;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          s_r     <= SHA_H0;
          w_r     <= blk_to_window(pad_block(key_high_r, key_low_r, IPAD_BYTE));
          round_r <= '0;
          state_r <= ST_IPAD;
        end
        ST_IPAD: begin
          if (round_r == LAST_ROUND) begin
            ipad_h_r <= sha_add(SHA_H0, s_step);
            s_r      <= SHA_H0;
            w_r      <= blk_to_window(pad_block(key_high_r, key_low_r, OPAD_BYTE));
            round_r  <= '0;
            state_r  <= ST_OPAD;
          end else begin
            s_r     <= s_step;
            w_r     <= sha_next_win(w_r);
            round_r <= round_r + 7'd1;
          end
        end
        ST_OPAD: begin
          if (round_r == LAST_ROUND) begin
            opad_h_r <= sha_add(SHA_H0, s_step);
            round_r  <= '0;
            state_r  <= ST_READY;
          end else begin
            s_r     <= s_step;
            w_r     <= sha_next_win(w_r);
            round_r <= round_r + 7'd1;
          end
        end
        ST_READY: begin
          round_r <= '0;
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign pad.busy   = (state_r != ST_READY);
  assign pad.ipad_h = ipad_h_r;
  assign pad.opad_h = opad_h_r;

endmodule

[tb/tb_hmac_sha1_otp_verifier.sv]
// Self-checking bench for the HOTP/TOTP verifier: HMAC-SHA1 predictor, random traffic, key sweeps.
module tb_hmac_sha1_otp_verifier;
  timeunit 1ns;
  timeprecision 1ps;

  import hsov_pkg::*;

  localparam int unsigned CODE_MOD    = 1000000;
  localparam int unsigned SETTLE      = 250;     // > pipeline latency and pad rehash
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 300;

  class code_scoreboard;
    bit [15:0] key_high;
    bit [63:0] key_low;
    result_t   awaited_codes[$];
    int unsigned checked;
    int unsigned matched;
    int unsigned errors;

    function bit [159:0] sha1_compress(bit [159:0] hv, bit [511:0] blk);
      bit [31:0] w[80];
      bit [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
      for (int i = 16; i < 80; i++) begin
        t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {t[30:0], t[31]};
      end
      {a, b, c, d, e} = hv;
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5a827999;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ed9eba1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8f1bbcdc;
        end else begin
          f = b ^ c ^ d;
          k = 32'hca62c1d6;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
    endfunction

    function bit [CODE_W-1:0] hotp_code(op_t mode, bit [63:0] value);
      bit [159:0] h_init;
      bit [63:0]  factor;
      bit [511:0] key_blk;
      bit [511:0] blk;
      bit [159:0] inner;
      bit [159:0] mac;
      int         off;
      bit [31:0]  bin;
      h_init  = 160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
      factor  = (mode == OP_TIME) ? value / 64'd30 : value;
      key_blk = {key_high, key_low, 432'd0};
      blk     = {factor, 8'h80, 376'd0, 64'd576};
      inner   = sha1_compress(sha1_compress(h_init, key_blk ^ {64{8'h36}}), blk);
      blk     = {inner, 8'h80, 280'd0, 64'd672};
      mac     = sha1_compress(sha1_compress(h_init, key_blk ^ {64{8'h5c}}), blk);
      off     = int'(mac[3:0]);
      bin     = mac[159-8*off -: 32];
      bin[31] = 1'b0;
      return CODE_W'(bin % CODE_MOD);
    endfunction

    function void log_request(op_t mode, bit [63:0] value, bit [CODE_W-1:0] cand);
      result_t r;
      r.computed_code = hotp_code(mode, value);
      r.code_valid    = (cand == r.computed_code);
      awaited_codes.push_back(r);
    endfunction

    function void check_result(logic code_valid, logic [CODE_W-1:0] code);
      result_t want;
      if (awaited_codes.size() == 0) begin
        $display("%0t: result with none awaited: expected nothing, got valid=%0b code=%0d",
                 $time, code_valid, code);
        errors++;
        return;
      end
      want = awaited_codes.pop_front();
      checked++;
      if (want.code_valid) matched++;
      if (code_valid !== want.code_valid) begin
        $display("%0t: code_valid mismatch: expected %0b, actual %0b",
                 $time, want.code_valid, code_valid);
        errors++;
      end
      if (code !== want.computed_code) begin
        $display("%0t: computed_code mismatch: expected %0d, actual %0d",
                 $time, want.computed_code, code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hsov_in_if  in_ch();
  hsov_out_if out_ch();

  code_scoreboard sb = new();

  int unsigned cycle_count  = 0;
  int unsigned results_seen = 0;
  int unsigned key_settings = 0;
  bit          no_idle      = 1'b0;
  bit          hold_pending = 1'b0;
  int unsigned hold_at      = 0;
  int unsigned holds_done   = 0;

  hmac_sha1_otp_verifier #(.CODE_MODULUS(CODE_MOD)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.log_request(op_t'(in_ch.op), in_ch.moving_value, in_ch.candidate_code);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.code_valid, out_ch.computed_code);
        results_seen++;
      end
    end
  end

  // mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls plus one-shot long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending && results_seen >= hold_at) begin
        hold_pending = 1'b0;
        holds_done++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && !no_idle) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_request(input op_t mode, input logic [63:0] value,
                              input logic [CODE_W-1:0] cand);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= mode;
    in_ch.moving_value   <= value;
    in_ch.candidate_code <= cand;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.awaited_codes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_HIGH) sb.key_high = data[15:0];
    else sb.key_low = data;
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {$urandom, $urandom};
      4, 5:       return 64'($urandom_range(0, 1000));
      6, 7:       return 64'd1700000000 + 64'($urandom_range(0, 100000000));
      8:          return ~64'd0 - 64'($urandom_range(0, 100));
      default:    return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_cand(input logic [CODE_W-1:0] code);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return code;
    if (r < 45) return CODE_W'((int'(code) + 1) % CODE_MOD);
    if (r < 85) return CODE_W'($urandom_range(0, CODE_MOD - 1));
    return CODE_W'($urandom_range(0, 20'hfffff));
  endfunction

  task automatic send_matching(input op_t mode, input logic [63:0] value);
    send_request(mode, value, sb.hotp_code(mode, value));
  endtask

  task automatic run_directed();
    send_request(OP_COUNTER, 64'd0, 20'd0);
    send_matching(OP_COUNTER, 64'd0);
    send_request(OP_COUNTER, ~64'd0, 20'd999999);
    send_matching(OP_COUNTER, ~64'd0);
    send_request(OP_COUNTER, 64'd1, 20'hfffff);        // candidate above range
    send_request(OP_COUNTER, 64'd1, 20'd1000000);
    send_matching(OP_COUNTER, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(OP_COUNTER, 64'h5555_5555_5555_5555, 20'h55555);
    send_request(OP_COUNTER, 64'h8000_0000_0000_0000, 20'haaaaa);
    send_matching(OP_TIME, 64'd0);
    send_matching(OP_TIME, 64'd29);                    // same step as zero
    send_matching(OP_TIME, 64'd30);
    send_request(OP_TIME, 64'd59, 20'd0);
    send_matching(OP_TIME, 64'd60);
    send_matching(OP_TIME, 64'd1111111109);
    send_matching(OP_TIME, 64'd2000000000);
    send_matching(OP_TIME, ~64'd0);
    send_request(OP_TIME, ~64'd0 - 64'd29, 20'd123456);
  endtask

  // short runs of consecutive counters / time steps, as a verifier window would send
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    op_t         mode;
    logic [63:0] value;
    sent = 0;
    while (sent < count) begin
      mode  = op_t'($urandom_range(0, 1));
      value = rand_value();
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(mode, value, pick_cand(sb.hotp_code(mode, value)));
        value = value + ((mode == OP_TIME) ? 64'd30 : 64'd1);
        sent++;
      end
    end
  endtask

  task automatic run_phase(input bit set_high, input logic [63:0] high_data,
                           input bit set_low, input logic [63:0] low_data,
                           input bit hold, input bit steady);
    wait_idle();
    if (set_high) write_reg(CFG_KEY_HIGH, high_data);
    if (set_low) write_reg(CFG_KEY_LOW, low_data);
    key_settings++;
    no_idle = steady;
    if (hold) begin
      hold_at = results_seen + 20;
      hold_pending = 1'b1;
    end
    run_random(PHASE_ITEMS);
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    in_ch.valid          = 1'b0;
    in_ch.op             = 1'b0;
    in_ch.moving_value   = '0;
    in_ch.candidate_code = '0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    rst_n                = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // reset key is all zero
    key_settings = 1;
    repeat (SETTLE) @(negedge clk);
    run_directed();
    run_phase(1'b1, ~64'd0, 1'b1, ~64'd0, 1'b0, 1'b0);
    run_phase(1'b1, 64'h3132, 1'b1, 64'h3334_3536_3738_3930, 1'b1, 1'b0);
    run_phase(1'b1, {$urandom, $urandom}, 1'b1, {$urandom, $urandom}, 1'b0, 1'b1);
    // upper data bits must be ignored by the 16-bit register
    run_phase(1'b1, 64'hdead_beef_0000_8000, 1'b0, 64'd0, 1'b1, 1'b0);
    run_phase(1'b0, 64'd0, 1'b1, 64'd1, 1'b0, 1'b0);
    run_phase(1'b1, {$urandom, $urandom}, 1'b1, {$urandom, $urandom}, 1'b0, 1'b0);
    in_ch.valid <= 1'b0;
    while (sb.awaited_codes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("Checked %0d codes (%0d matches) in counter and time modes over %0d keys,",
             sb.checked, sb.matched, key_settings);
    $display("with random stalls on both sides and %0d long output hold-offs.", holds_done);
    if (sb.errors == 0 && sb.awaited_codes.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
src/hsov_pkg.sv
src/hsov_if.sv
src/hsov_div_cell.sv
src/hsov_sha_cell.sv
src/hsov_mod_cell.sv
src/hsov_key_engine.sv
src/hmac_sha1_otp_verifier.sv
tb/tb_hmac_sha1_otp_verifier.sv
